[rtl/acpc_pkg.sv]
// ----------------------------------------------------------------------------
// acpc_pkg
// shared types, codes and per-character parse functions of the command parser
// ----------------------------------------------------------------------------
package acpc_pkg;

  localparam int unsigned MsgBufferBytesDef = 96;

  // field stage codes: awaiting first char, begun = code + FldBegunOfs
  localparam logic [3:0] FLD_IDLE    = 4'd0;
  localparam logic [3:0] FLD_X       = 4'd1;
  localparam logic [3:0] FLD_Y       = 4'd2;
  localparam logic [3:0] FLD_Z       = 4'd3;
  localparam logic [3:0] FLD_ANG     = 4'd4;
  localparam logic [3:0] FLD_CUR     = 4'd5;
  localparam logic [3:0] FldBegunOfs = 4'd5;

  localparam logic [2:0] POS_DONE  = 3'd5;
  localparam logic [2:0] GRIP_DONE = 3'd4;

  typedef enum logic [9:0] {
    STOP_IDLE = 10'b00_0000_0001,
    STOP_S    = 10'b00_0000_0010,
    STOP_ST   = 10'b00_0000_0100,
    STOP_STC  = 10'b00_0000_1000,
    STOP_STP  = 10'b00_0001_0000,
    STOP_STPS = 10'b00_0010_0000,
    STOP_Z    = 10'b00_0100_0000,
    STOP_ZT   = 10'b00_1000_0000,
    STOP_ZTS  = 10'b01_0000_0000,
    STOP_DEAD = 10'b10_0000_0000
  } stop_e;

  typedef struct packed {
    logic        after_delim;
    logic [2:0]  pos_prog;
    logic [2:0]  grip_prog;
    stop_e       stop;
    logic [3:0]  field;
    logic [31:0] acc;
    logic        neg;
    logic        seen;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic [11:0] angle;
    logic [15:0] current;
    logic [1:0]  flags;
    logic        failed;
    logic        term;
  } parse_state_t;

  typedef struct packed {
    logic        message_valid;
    logic [1:0]  command_kind;
    logic        position_present;
    logic        gripper_present;
    logic [31:0] target_x;
    logic [31:0] target_y;
    logic [31:0] target_z;
    logic [11:0] grip_angle;
    logic [15:0] grip_current;
  } result_t;

  function automatic parse_state_t reset_state();
    parse_state_t r;
    r             = '0;
    r.after_delim = 1'b1;
    r.stop        = STOP_IDLE;
    return r;
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return (c == 8'h00) || (c == ",") || (c == "/") || (c == "_") || (c == " ") ||
           (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
  endfunction

  function automatic logic [7:0] pos_word(logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd1:    ch = "X";
      3'd2:    ch = "Y";
      3'd3:    ch = "Z";
      3'd4:    ch = ":";
      default: ch = "P";
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] grip_word(logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd1:    ch = "Z";
      3'd2:    ch = "H";
      3'd3:    ch = "_";
      default: ch = "J";
    endcase
    return ch;
  endfunction

  function automatic stop_e stop_next(stop_e s, logic [7:0] c);
    stop_e n;
    case (s)
      STOP_IDLE: n = (c == "S") ? STOP_S : ((c == "Z") ? STOP_Z : STOP_DEAD);
      STOP_S:    n = (c == "T") ? STOP_ST : STOP_DEAD;
      STOP_ST:   n = (c == ":") ? STOP_STC : STOP_DEAD;
      STOP_STC:  n = (c == "P") ? STOP_STP : STOP_DEAD;
      STOP_STP:  n = (c == "/") ? STOP_STPS : STOP_DEAD;
      STOP_Z:    n = (c == "T") ? STOP_ZT : STOP_DEAD;
      STOP_ZT:   n = (c == "/") ? STOP_ZTS : STOP_DEAD;
      default:   n = STOP_DEAD;
    endcase
    return n;
  endfunction

  function automatic parse_state_t parse_char(parse_state_t s, logic [7:0] c);
    parse_state_t       r;
    logic [3:0]         f;
    logic [35:0]        lim;
    logic [35:0]        nv;
    logic signed [32:0] sv;
    r   = s;
    f   = (s.field > FldBegunOfs) ? (s.field - FldBegunOfs) : s.field;
    lim = s.neg ? 36'h0_8000_0000 : 36'h0_7fff_ffff;
    // acc * 10 + digit as two shifts and adds
    nv  = {1'b0, s.acc, 3'b000} + {3'b000, s.acc, 1'b0} + {32'd0, c[3:0]};
    sv  = s.neg ? -$signed({1'b0, s.acc}) : $signed({1'b0, s.acc});
    if (s.field != FLD_IDLE) begin
      if ((s.field <= FLD_CUR) && ((c == "+") || (c == "-"))) begin
        r.neg   = (c == "-");
        r.field = f + FldBegunOfs;
      end else if ((c >= "0") && (c <= "9")) begin
        if (nv > lim) begin
          r.failed = 1'b1;
          r.field  = FLD_IDLE;
        end else begin
          r.acc   = nv[31:0];
          r.seen  = 1'b1;
          r.field = f + FldBegunOfs;
        end
      end else if (!s.seen) begin
        r.failed = 1'b1;
        r.field  = FLD_IDLE;
      end else begin
        r.acc  = '0;
        r.neg  = 1'b0;
        r.seen = 1'b0;
        if (f <= FLD_Z) begin
          if (c != ",") begin
            r.failed = 1'b1;
            r.field  = FLD_IDLE;
          end else begin
            case (f)
              FLD_X:   r.coord_x = sv[31:0];
              FLD_Y:   r.coord_y = sv[31:0];
              default: r.coord_z = sv[31:0];
            endcase
            r.field = (f < FLD_Z) ? (f + 4'd1) : FLD_IDLE;
          end
        end else if (f == FLD_ANG) begin
          if ((c != "_") || (sv < -33'sd2000) || (sv > 33'sd2000)) begin
            r.failed = 1'b1;
            r.field  = FLD_IDLE;
          end else begin
            r.angle = sv[11:0];
            r.field = FLD_CUR;
          end
        end else begin
          if ((sv < 33'sd0) || (sv > 33'sd65535) || !is_delim(c)) begin
            r.failed = 1'b1;
            r.field  = FLD_IDLE;
          end else begin
            r.current = sv[15:0];
            r.field   = FLD_IDLE;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic parse_state_t text_char(parse_state_t s, logic [7:0] c);
    parse_state_t r;
    r = s;
    if (!s.failed) begin
      r = parse_char(s, c);
      if (!r.failed) begin
        if ((s.pos_prog != 3'd0) && (s.pos_prog < POS_DONE) && (c == pos_word(s.pos_prog)))
          r.pos_prog = s.pos_prog + 3'd1;
        else
          r.pos_prog = ((c == "P") && s.after_delim) ? 3'd1 : 3'd0;
        if (r.pos_prog == POS_DONE) begin
          r.pos_prog = 3'd0;
          if (!r.flags[0] && (r.field == FLD_IDLE)) begin
            r.flags[0] = 1'b1;
            r.field    = FLD_X;
          end
        end
        if ((s.grip_prog != 3'd0) && (s.grip_prog < GRIP_DONE) &&
            (c == grip_word(s.grip_prog)))
          r.grip_prog = s.grip_prog + 3'd1;
        else
          r.grip_prog = ((c == "J") && s.after_delim) ? 3'd1 : 3'd0;
        if (r.grip_prog == GRIP_DONE) begin
          r.grip_prog = 3'd0;
          if (!r.flags[1] && (r.field == FLD_IDLE)) begin
            r.flags[1] = 1'b1;
            r.field    = FLD_ANG;
          end
        end
        if (c != 8'h00) r.stop = stop_next(s.stop, c);
        r.after_delim = is_delim(c);
      end
    end
    return r;
  endfunction

endpackage

[rtl/acpc_parse.sv]
// ----------------------------------------------------------------------------
// acpc_parse
// input word register, message parse state and per-byte update logic
// ----------------------------------------------------------------------------
module acpc_parse #(
  parameter int unsigned MSG_BUFFER_BYTES = acpc_pkg::MsgBufferBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [7:0]        s_byte_i,
  input  logic              s_last_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output acpc_pkg::result_t res_o
);

  localparam int unsigned CntW = $clog2(MSG_BUFFER_BYTES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MSG_BUFFER_BYTES);

  logic                   in_valid_q;
  logic [7:0]             in_byte_q;
  logic                   in_last_q;
  logic [CntW-1:0]        cnt_q, cnt_d;
  acpc_pkg::parse_state_t st_q, st_d, st_byte, st_end;
  logic                   advance;
  logic                   stop_ok;

  assign advance     = in_valid_q && (!in_last_q || res_ready_i);
  assign s_ready_o   = !in_valid_q || advance;
  assign res_valid_o = in_valid_q && in_last_q;

  always_comb begin
    cnt_d   = (cnt_q < CntMax) ? (cnt_q + CntW'(1)) : cnt_q;
    st_byte = st_q;
    if (!st_q.term) begin
      st_byte = acpc_pkg::text_char(st_q, in_byte_q);
      if (in_byte_q == 8'h00) st_byte.term = 1'b1;
    end
    // end of message closes any open clause with a nul
    st_end = st_byte;
    if (!st_byte.term) begin
      st_end      = acpc_pkg::text_char(st_byte, 8'h00);
      st_end.term = 1'b1;
    end
    stop_ok = (st_end.stop == acpc_pkg::STOP_STP) || (st_end.stop == acpc_pkg::STOP_STPS) ||
              (st_end.stop == acpc_pkg::STOP_ZT)  || (st_end.stop == acpc_pkg::STOP_ZTS);
    res_o = '0;
    if (!st_end.failed && (cnt_d < CntMax) && (st_end.field == acpc_pkg::FLD_IDLE) &&
        ((st_end.flags != 2'b00) || stop_ok)) begin
      res_o.message_valid    = 1'b1;
      res_o.command_kind     = st_end.flags;
      res_o.position_present = st_end.flags[0];
      res_o.gripper_present  = st_end.flags[1];
      if (st_end.flags[0]) begin
        res_o.target_x = st_end.coord_x;
        res_o.target_y = st_end.coord_y;
        res_o.target_z = st_end.coord_z;
      end
      if (st_end.flags[1]) begin
        res_o.grip_angle   = st_end.angle;
        res_o.grip_current = st_end.current;
      end
    end
    st_d = in_last_q ? acpc_pkg::reset_state() : st_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      cnt_q      <= '0;
      st_q       <= acpc_pkg::reset_state();
    end else begin
      if (s_ready_o) in_valid_q <= s_valid_i;
      if (advance) begin
        cnt_q <= in_last_q ? '0 : cnt_d;
        st_q  <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      in_byte_q <= s_byte_i;
      in_last_q <= s_last_i;
    end
  end

endmodule

[rtl/acpc_out_reg.sv]
// ----------------------------------------------------------------------------
// acpc_out_reg
// result register between the parse logic and the output stream
// ----------------------------------------------------------------------------
module acpc_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  acpc_pkg::result_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output acpc_pkg::result_t out_data_o
);

  logic              valid_q;
  acpc_pkg::result_t data_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) data_q <= in_data_i;
  end

endmodule

[rtl/ascii_arm_command_parser_core.sv]
// ----------------------------------------------------------------------------
// ascii_arm_command_parser_core
// parses one ascii arm command message per run of input words
// ----------------------------------------------------------------------------
// usage: each input word on s_axis carries one message byte, tlast marks the
// final byte. non-last words give no result; the last word gives exactly one
// result word on m_axis with the command kind, presence flags and values, or
// all zero when the message is not a legal command.
// throughput: one input word per cycle, sustained, including across message
// boundaries, unless the last byte of a message waits on a full, stalled result
// register. the byte sits in an input register, one pass of matcher and
// digit-accumulate logic updates the parse state, and the result lands in an
// output register, from which m_axis presents the result word.
// stall: while m_axis_tready is low the result register holds; the block keeps
// taking non-last bytes of the next message and stops only at its last byte.
// reset: clears the parse state to start of text and drops both valid flags.
// ----------------------------------------------------------------------------
module ascii_arm_command_parser_core #(
  parameter int unsigned MSG_BUFFER_BYTES = acpc_pkg::MsgBufferBytesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,  // [7:0] rx_byte
  input  logic         s_axis_tlast_i,  // end_of_message
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [31:0] target_x, [63:32] target_y, [95:64] target_z, [107:96] grip_angle,
  // [123:108] grip_current, [127:124] zero
  output logic [127:0] m_axis_tdata_o,
  // [0] message_valid, [2:1] command_kind, [3] position_present,
  // [4] gripper_present
  output logic [4:0]   m_axis_tuser_o
);

  logic              res_valid, res_ready;
  acpc_pkg::result_t res, out_res;

  acpc_parse #(
    .MSG_BUFFER_BYTES(MSG_BUFFER_BYTES)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid_i),
    .s_ready_o  (s_axis_tready_o),
    .s_byte_i   (s_axis_tdata_i),
    .s_last_i   (s_axis_tlast_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  acpc_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_valid),
    .in_ready_o (res_ready),
    .in_data_i  (res),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_data_o (out_res)
  );

  assign m_axis_tdata_o = {4'd0, out_res.grip_current, out_res.grip_angle,
                           out_res.target_z, out_res.target_y, out_res.target_x};
  assign m_axis_tuser_o = {out_res.gripper_present, out_res.position_present,
                           out_res.command_kind, out_res.message_valid};

endmodule

[rtl/acpc_checker.sv]
// ----------------------------------------------------------------------------
// acpc_checker
// port-level checks on the result stream of the command parser
// ----------------------------------------------------------------------------
module acpc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [127:0] m_axis_tdata_o,
  input logic [4:0]   m_axis_tuser_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word dropped while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == '0 && m_axis_tuser_o == '0)
    else $error("invalid message with nonzero fields");

  a_kind_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o[2:1] == m_axis_tuser_o[4:3])
    else $error("command kind disagrees with presence flags");

  a_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[3] |-> m_axis_tdata_o[95:0] == '0)
    else $error("coordinates set without position clause");

  a_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[107:96]) >= -12'sd2000) &&
                        ($signed(m_axis_tdata_o[107:96]) <= 12'sd2000))
    else $error("grip angle out of range");

endmodule

bind ascii_arm_command_parser_core acpc_checker u_acpc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);
